// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define CHK_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/wcv_pkg.sv =====
// types and constants shared by the variance block
package wcv_pkg;

    localparam int unsigned SampleW = 32;
    localparam int unsigned MeanW   = 48;
    localparam int unsigned SsdW    = 64;
    localparam int unsigned CvW     = 32;
    localparam int unsigned ThrW    = 25;
    localparam logic [ThrW-1:0] ThrReset = 25'd1678;

    // unit operation selects
    typedef enum logic [1:0] {
        OP_DIV_MEAN = 2'd0,
        OP_DIV_VAR  = 2'd1,
        OP_SQRT     = 2'd2,
        OP_DIV_CV   = 2'd3
    } wcv_op_t;

    typedef struct packed {
        logic    seed;
        logic    load_in;
        logic    start_op;
        wcv_op_t op;
        logic    upd_mean;
        logic    mul_hi;
        logic    upd_ssd;
        logic    finish;
    } wcv_cmd_t;

    typedef struct packed {
        logic first;
        logic op_done;
        logic mean_zero;
    } wcv_sts_t;

endpackage

// ===== rtl/wcv_ctrl.sv =====
// sequencer per sample: seed a first sample, else mean divide, update; if mean != 0, variance divide, root, cv divide
module wcv_ctrl
    import wcv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  logic     out_free,
    input  wcv_sts_t sts,
    output wcv_cmd_t cmd,
    output logic     busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MDIV, S_MWAIT, S_MUPD, S_MUL, S_SSD,
        S_VDIV, S_VWAIT, S_ROOT, S_RWAIT, S_CDIV, S_CWAIT, S_DONE
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE:  if (in_fire) state_reg <= S_CHECK;
                S_CHECK: state_reg <= sts.first ? S_DONE : S_MDIV;
                S_MDIV:  state_reg <= S_MWAIT;
                S_MWAIT: if (sts.op_done) state_reg <= S_MUPD;
                S_MUPD:  state_reg <= S_MUL;
                S_MUL:   state_reg <= S_SSD;
                S_SSD:   state_reg <= sts.mean_zero ? S_DONE : S_VDIV;
                S_VDIV:  state_reg <= S_VWAIT;
                S_VWAIT: if (sts.op_done) state_reg <= S_ROOT;
                S_ROOT:  state_reg <= S_RWAIT;
                S_RWAIT: if (sts.op_done) state_reg <= S_CDIV;
                S_CDIV:  state_reg <= S_CWAIT;
                S_CWAIT: if (sts.op_done) state_reg <= S_DONE;
                S_DONE:  if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd = '0;
        cmd.load_in = (state_reg == S_IDLE) && in_fire;
        cmd.seed = (state_reg == S_CHECK) && sts.first;
        case (state_reg)
            S_MDIV: begin cmd.start_op = 1'b1; cmd.op = OP_DIV_MEAN; end
            S_VDIV: begin cmd.start_op = 1'b1; cmd.op = OP_DIV_VAR; end
            S_ROOT: begin cmd.start_op = 1'b1; cmd.op = OP_SQRT; end
            S_CDIV: begin cmd.start_op = 1'b1; cmd.op = OP_DIV_CV; end
            default: cmd.op = OP_DIV_MEAN;
        endcase
        cmd.upd_mean = (state_reg == S_MUPD);
        cmd.mul_hi = (state_reg == S_MUL);
        cmd.upd_ssd = (state_reg == S_SSD);
        cmd.finish = (state_reg == S_DONE) && out_free;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/wcv_unit.sv =====
// shared iterative unit: 128/64 restoring divide and 128-bit integer root
module wcv_unit
    import wcv_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          is_sqrt,
    input  logic [127:0]  num,
    input  logic [63:0]   den,
    output logic [127:0]  res,
    output logic          done
);

    logic [127:0] n_reg, q_reg, bit_reg;
    logic [63:0]  r_reg, d_reg;
    logic [6:0]   cnt_reg;
    logic         run_reg, sq_reg, done_reg;

    logic [64:0]  rs;
    logic [64:0]  rdiff;
    logic [127:0] t;

    assign rs = {r_reg, n_reg[127]};
    assign rdiff = rs - {1'b0, d_reg};
    assign t = q_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                sq_reg  <= is_sqrt;
                n_reg   <= num;
                d_reg   <= den;
                r_reg   <= '0;
                q_reg   <= '0;
                bit_reg <= {2'b01, 126'd0};
                cnt_reg <= 7'd127;
            end else if (run_reg) begin
                if (!sq_reg) begin
                    n_reg <= {n_reg[126:0], 1'b0};
                    if (rs[64] || !rdiff[64]) begin
                        r_reg <= rdiff[63:0];
                        q_reg <= {q_reg[126:0], 1'b1};
                    end else begin
                        r_reg <= rs[63:0];
                        q_reg <= {q_reg[126:0], 1'b0};
                    end
                    if (cnt_reg == 7'd0) begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                end else begin
                    if (n_reg >= t) begin
                        n_reg <= n_reg - t;
                        q_reg <= (q_reg >> 1) + bit_reg;
                    end else begin
                        q_reg <= q_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0] || bit_reg[1]) begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign res = q_reg;
    assign done = done_reg;

endmodule

// ===== rtl/wcv_dp.sv =====
// datapath: series state, welford update, result fields
module wcv_dp
    import wcv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  wcv_cmd_t            cmd,
    output wcv_sts_t            sts,
    input  logic [SampleW-1:0]  sample,
    input  logic                series_start,
    input  logic [ThrW-1:0]     cv_threshold,
    output logic [SampleW-1:0]  run_count,
    output logic [MeanW-1:0]    mean_value,
    output logic [CvW-1:0]      variation_coefficient,
    output logic                converged
);

    logic [31:0]  count_reg;
    logic [47:0]  mean_reg, x_reg, dmag_reg;
    logic [63:0]  ssd_reg;
    logic [31:0]  last_cv_reg, cv_reg;
    logic         conv_reg, neg_reg, start_reg, zero_reg;
    logic [95:0]  prod_reg;
    logic [127:0] var_reg;

    logic         u_start, u_sqrt, u_done;
    logic [127:0] u_num, u_res;
    logic [63:0]  u_den;
    wcv_op_t      op_reg;

    logic [47:0]  step, mean_new, rmag, rmag_new;
    logic         neg_w;
    logic [47:0]  dmag_w;
    logic [31:0]  count_inc;
    logic [71:0]  pp_lo, pp_hi;
    logic [79:0]  inc_w;
    logic [63:0]  inc;
    logic [64:0]  ssd_sum;
    logic [31:0]  cv_sat, diff;

    assign neg_w = x_reg < mean_reg;
    assign dmag_w = neg_w ? mean_reg - x_reg : x_reg - mean_reg;
    assign count_inc = (count_reg != '1) ? count_reg + 32'd1 : count_reg;
    assign step = u_res[47:0];
    assign mean_new = neg_reg ? mean_reg - step : mean_reg + step;
    assign rmag = neg_reg ? mean_reg - x_reg : x_reg - mean_reg;
    assign rmag_new = neg_reg ? mean_new - x_reg : x_reg - mean_new;
    // product split over the update and multiply states on the low and high halves of the residual
    assign pp_lo = 72'(dmag_reg) * 72'(rmag_new[23:0]);
    assign pp_hi = 72'(dmag_reg) * 72'(rmag[47:24]);
    assign inc_w = prod_reg[95:16];
    assign inc = (inc_w[79:64] != 16'd0) ? '1 : inc_w[63:0];
    assign ssd_sum = {1'b0, ssd_reg} + {1'b0, inc};
    assign cv_sat = (u_res[127:32] != '0) ? '1 : u_res[31:0];
    assign diff = (cv_sat >= last_cv_reg) ? cv_sat - last_cv_reg : last_cv_reg - cv_sat;

    always_comb begin
        u_num = '0;
        u_den = '0;
        u_sqrt = 1'b0;
        case (cmd.op)
            OP_DIV_MEAN: begin u_num = {80'd0, dmag_w}; u_den = {32'd0, count_inc}; end
            OP_DIV_VAR:  begin u_num = {48'd0, ssd_reg, 16'd0}; u_den = {32'd0, count_reg}; end
            OP_SQRT:     begin u_num = var_reg; u_sqrt = 1'b1; end
            OP_DIV_CV:   begin u_num = {u_res[103:0], 24'd0}; u_den = {16'd0, mean_reg}; end
            default:     u_num = '0;
        endcase
    end
    assign u_start = cmd.start_op;

    wcv_unit u_unit (
        .aclk(aclk), .aresetn(aresetn), .start(u_start), .is_sqrt(u_sqrt),
        .num(u_num), .den(u_den), .res(u_res), .done(u_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            mean_reg    <= '0;
            ssd_reg     <= '0;
            last_cv_reg <= '0;
        end else begin
            if (cmd.start_op) op_reg <= cmd.op;
            if (cmd.load_in) begin
                x_reg     <= {sample, 16'd0};
                start_reg <= series_start;
            end
            if (cmd.seed) begin
                count_reg   <= 32'd1;
                mean_reg    <= x_reg;
                ssd_reg     <= '0;
                last_cv_reg <= '0;
                cv_reg      <= '0;
                conv_reg    <= 1'b0;
            end
            if (sts.first == 1'b0 && cmd.start_op && cmd.op == OP_DIV_MEAN) begin
                count_reg <= count_inc;
                neg_reg   <= neg_w;
                dmag_reg  <= dmag_w;
            end
            if (cmd.upd_mean) begin
                mean_reg <= mean_new;
                zero_reg <= (mean_new == '0);
                prod_reg <= {24'd0, pp_lo};
            end
            if (cmd.mul_hi) prod_reg <= prod_reg + {pp_hi, 24'd0};
            if (u_done && op_reg == OP_DIV_VAR) var_reg <= u_res;
            if (u_done && op_reg == OP_DIV_CV) begin
                cv_reg      <= cv_sat;
                conv_reg    <= diff <= {7'd0, cv_threshold};
                last_cv_reg <= cv_sat;
            end
            if (cmd.upd_ssd) begin
                ssd_reg <= ssd_sum[64] ? '1 : ssd_sum[63:0];
                if (zero_reg) begin
                    cv_reg      <= '0;
                    conv_reg    <= 1'b1;
                    last_cv_reg <= '0;
                end
            end
        end
    end

    assign sts.first = start_reg || (count_reg == '0);
    assign sts.op_done = u_done;
    assign sts.mean_zero = zero_reg;

    assign run_count = count_reg;
    assign mean_value = mean_reg;
    assign variation_coefficient = cv_reg;
    assign converged = conv_reg;

endmodule

// ===== rtl/welford_cv_convergence.sv =====
// top level of the running-variance block with cv convergence test
//  channel  dir  tdata                                  tuser
//  s_       in   sample[31:0]                           series_start
//  m_       out  run_count, mean_value, cv (112 bits)   converged
//  cfg      in   cv_threshold[24:0]                     -
// a full update runs three 128-step divides and a 64-step root in turn
// through one shared iterative unit; a zero mean skips variance, root and cv
// aresetn clears the series state and loads the default threshold
// the result is held in an output register until taken; the next transfer is
// accepted once the result is loaded, a held result stalls the next finish
module welford_cv_convergence
    import wcv_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // sample
    input  logic          s_tuser,   // series_start
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // run_count, mean_value, variation_coefficient
    output logic          m_tuser,   // converged
    input  logic          cfg_wr_en,
    input  logic [24:0]   cfg_wr_data
);

    logic [ThrW-1:0] thr_reg;
    wcv_cmd_t cmd;
    wcv_sts_t sts;
    logic busy, in_fire, out_free;
    logic [31:0] rc, cvv;
    logic [47:0] mv;
    logic cg;
    logic mvalid_reg;
    logic [111:0] mdata_reg;
    logic muser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= ThrReset;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = !busy;
    assign in_fire = s_tvalid && s_tready;

    wcv_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .cmd(cmd), .busy(busy)
    );

    wcv_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .sample(s_tdata), .series_start(s_tuser), .cv_threshold(thr_reg),
        .run_count(rc), .mean_value(mv), .variation_coefficient(cvv), .converged(cg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                mvalid_reg <= 1'b1;
                mdata_reg  <= {cvv, mv, rc};
                muser_reg  <= cg;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = mdata_reg;
    assign m_tuser = muser_reg;

endmodule

// ===== rtl/wcv_checker.sv =====
// port-level checks for the variance block, bound to the top level
`include "assert_macros.svh"
module wcv_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tuser
);
    `CHK_NEXT(a_no_accept_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `CHK_IMPLY(a_count_nonzero, aclk, aresetn, m_tvalid, m_tdata[31:0] != 32'd0)
    `CHK_IMPLY(a_first_not_conv, aclk, aresetn, m_tvalid && m_tdata[31:0] == 32'd1, !m_tuser)
    `CHK_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind welford_cv_convergence wcv_checker u_wcv_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
